/* design/assert_macros.svh */
// assertion macros for the rtl files; only bpr_back.sv includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/bpr_pkg.sv */
// types, constants and the sine table of the bitmap pixel rotator
`default_nettype none

package bpr_pkg;

  localparam int COORD_BITS     = 10;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int OUT_BITS       = COORD_BITS + 2;
  localparam int ANGLE_BITS     = 9;
  localparam int COLOR_BITS     = 24;
  localparam int PROD_BITS      = COORD_BITS + TRIG_FRAC_BITS + 2;
  localparam int SUM_BITS       = PROD_BITS + 1;
  localparam int QUEUE_DEPTH    = 2;  // power of two, pointers wrap freely

  localparam int HALF_TURN      = 180;
  localparam int FULL_TURN      = 360;
  localparam int QUARTER_TURN   = 90;
  localparam int TAB_IDX_BITS   = $clog2(QUARTER_TURN + 1);
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = (COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS;

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_ORIGIN_X  = 3'd0;
  localparam cfg_idx_t REG_ORIGIN_Y  = 3'd1;
  localparam cfg_idx_t REG_ANCHOR_X  = 3'd2;
  localparam cfg_idx_t REG_ANCHOR_Y  = 3'd3;
  localparam cfg_idx_t REG_ANGLE_DEG = 3'd4;

  typedef logic [COORD_BITS-1:0]           coord_t;
  typedef logic signed [COORD_BITS:0]      delta_t;
  typedef logic [ANGLE_BITS-1:0]           angle_t;
  typedef logic [COLOR_BITS-1:0]           color_t;
  typedef logic [TRIG_FRAC_BITS:0]         trig_mag_t;
  typedef logic signed [TRIG_FRAC_BITS+1:0] trig_t;
  typedef logic signed [PROD_BITS-1:0]     prod_t;
  typedef logic signed [SUM_BITS-1:0]      sum_t;
  typedef logic signed [OUT_BITS-1:0]      out_t;
  typedef logic [TAB_IDX_BITS-1:0]         tab_idx_t;
  typedef trig_mag_t sin_tab_t [QUARTER_TURN+1];

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t anchor_x;
    coord_t anchor_y;
    angle_t angle_deg;
  } cfg_t;

  typedef struct packed {
    delta_t dx;
    delta_t dy;
    trig_t  sin_v;
    trig_t  cos_v;
    color_t color;
    logic   eoi;
  } queue_entry_t;

  // bias that turns a floor shift into truncation toward zero for negative sums
  localparam sum_t TRUNC_BIAS = sum_t'((1 << TRIG_FRAC_BITS) - 1);

  // sin of r degrees (0..90), q30 taylor series rounded to the table format
  function automatic trig_mag_t sin_quarter(input int unsigned r);
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint          sum;
    longint          v;
    a    = (PI_Q30 * longint'(r)) / HALF_TURN;
    a2   = (a * a) >> 30;
    term = a;
    sum  = longint'(a);
    // each term is the one before times a^2 over (2k)(2k+1), signs alternate
    term = ((term * a2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * a2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * a2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * a2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * a2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * a2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    term = ((term * a2) >> 30) / 64'd210;
    sum  = sum - longint'(term);
    term = ((term * a2) >> 30) / 64'd272;
    sum  = sum + longint'(term);
    term = ((term * a2) >> 30) / 64'd342;
    sum  = sum - longint'(term);
    term = ((term * a2) >> 30) / 64'd420;
    sum  = sum + longint'(term);
    if (sum < 0) sum = 0;
    v = (sum + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
    if (v > (longint'(1) << TRIG_FRAC_BITS)) v = longint'(1) << TRIG_FRAC_BITS;
    return trig_mag_t'(v);
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t t;
    for (int r = 0; r <= QUARTER_TURN; r++) begin
      t[r] = sin_quarter(r);
    end
    return t;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

`default_nettype wire

/* design/bpr_if.sv */
// channel interfaces: pixel input, pixel write output, register write
`default_nettype none

interface bpr_in_if;
  logic                                valid;
  logic                                ready;
  logic [bpr_pkg::COORD_BITS-1:0]      src_x;
  logic [bpr_pkg::COORD_BITS-1:0]      src_y;
  logic [bpr_pkg::COLOR_BITS-1:0]      pixel_color;
  logic                                end_of_image;
  modport source (output valid, src_x, src_y, pixel_color, end_of_image, input ready);
  modport sink   (input valid, src_x, src_y, pixel_color, end_of_image, output ready);
endinterface

interface bpr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bpr_pkg::OUT_BITS-1:0] draw_x;
  logic signed [bpr_pkg::OUT_BITS-1:0] draw_y;
  logic [bpr_pkg::COLOR_BITS-1:0]      draw_color;
  logic                                pair_last;
  logic                                image_done;
  modport source (output valid, draw_x, draw_y, draw_color, pair_last, image_done,
                  input ready);
  modport sink   (input valid, draw_x, draw_y, draw_color, pair_last, image_done,
                  output ready);
endinterface

interface bpr_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [bpr_pkg::CFG_IDX_BITS-1:0]    reg_index;
  logic [bpr_pkg::CFG_DATA_BITS-1:0]   wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

/* design/bpr_front.sv */
// front end: takes pixels, forms anchor offsets and picks signed sin/cos
`default_nettype none

module bpr_front (
  bpr_in_if.sink                 in_pix,
  input  bpr_pkg::cfg_t          cfg,
  output logic                   push_valid,
  input  logic                   push_ready,
  output bpr_pkg::queue_entry_t  push_data
);
  import bpr_pkg::*;

  localparam logic [1:0] QUAD_FIRST  = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD  = 2'd2;
  localparam logic [1:0] QUAD_FOURTH = 2'd3;

  localparam angle_t ANGLE_FULL = angle_t'(FULL_TURN);
  localparam angle_t ANGLE_Q1   = angle_t'(QUARTER_TURN);
  localparam angle_t ANGLE_Q2   = angle_t'(2 * QUARTER_TURN);
  localparam angle_t ANGLE_Q3   = angle_t'(3 * QUARTER_TURN);

  angle_t    deg;
  angle_t    base;
  angle_t    rem;
  logic [1:0] quad;
  tab_idx_t  r_idx;
  tab_idx_t  c_idx;
  trig_t     sr;
  trig_t     cr;
  trig_t     sin_v;
  trig_t     cos_v;

  always_comb begin
    deg = (cfg.angle_deg >= ANGLE_FULL) ? cfg.angle_deg - ANGLE_FULL : cfg.angle_deg;
    if (deg >= ANGLE_Q3) begin
      quad = QUAD_FOURTH;
      base = ANGLE_Q3;
    end else if (deg >= ANGLE_Q2) begin
      quad = QUAD_THIRD;
      base = ANGLE_Q2;
    end else if (deg >= ANGLE_Q1) begin
      quad = QUAD_SECOND;
      base = ANGLE_Q1;
    end else begin
      quad = QUAD_FIRST;
      base = '0;
    end
    rem   = deg - base;
    r_idx = rem[TAB_IDX_BITS-1:0];
    c_idx = tab_idx_t'(QUARTER_TURN) - r_idx;
    sr    = $signed({1'b0, SIN_TAB[r_idx]});
    cr    = $signed({1'b0, SIN_TAB[c_idx]});
    // zero angle lands here too: sin 0, cos one, which passes the offset through
    case (quad)
      QUAD_FIRST: begin
        sin_v = sr;
        cos_v = cr;
      end
      QUAD_SECOND: begin
        sin_v = cr;
        cos_v = -sr;
      end
      QUAD_THIRD: begin
        sin_v = -sr;
        cos_v = -cr;
      end
      QUAD_FOURTH: begin
        sin_v = -cr;
        cos_v = sr;
      end
      default: begin
        sin_v = sr;
        cos_v = cr;
      end
    endcase
  end

  assign in_pix.ready     = push_ready;
  assign push_valid       = in_pix.valid;
  assign push_data.dx     = $signed({1'b0, in_pix.src_x}) - $signed({1'b0, cfg.anchor_x});
  assign push_data.dy     = $signed({1'b0, in_pix.src_y}) - $signed({1'b0, cfg.anchor_y});
  assign push_data.sin_v  = sin_v;
  assign push_data.cos_v  = cos_v;
  assign push_data.color  = in_pix.pixel_color;
  assign push_data.eoi    = in_pix.end_of_image;

endmodule

`default_nettype wire

/* design/bpr_queue.sv */
// short register queue between the front end and the rotate pipeline
`default_nettype none

module bpr_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  bpr_pkg::queue_entry_t  push_data,
  output logic                   pop_valid,
  input  logic                   pop_ready,
  output bpr_pkg::queue_entry_t  pop_data
);
  import bpr_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t          entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   count_next;
  logic                  push;
  logic                  pop;

  assign push_ready = (count != CNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

/* design/bpr_back.sv */
// back end: multiply, sum and truncate, then emit the two writes of each pixel
`default_nettype none
`include "assert_macros.svh"

module bpr_back (
  input  logic                   clk,
  input  logic                   rst,
  input  bpr_pkg::cfg_t          cfg,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  bpr_pkg::queue_entry_t  pop_data,
  bpr_out_if.source              out_pix
);
  import bpr_pkg::*;

  // product stage
  logic   s1_valid;
  prod_t  p_xc;
  prod_t  p_ys;
  prod_t  p_xs;
  prod_t  p_yc;
  color_t s1_color;
  logic   s1_eoi;

  // output register, phase 0 is the write at x, phase 1 the one at x + 1
  logic   o_valid;
  logic   o_phase;
  out_t   o_x;
  out_t   o_y;
  color_t o_color;
  logic   o_eoi;

  logic   o_load;
  logic   s1_load;
  sum_t   sum_x;
  sum_t   sum_y;
  out_t   x_next;
  out_t   y_next;

  function automatic out_t trunc_zero(input sum_t v);
    sum_t biased;
    sum_t shifted;
    biased  = v[SUM_BITS-1] ? v + TRUNC_BIAS : v;
    shifted = biased >>> TRIG_FRAC_BITS;
    return shifted[OUT_BITS-1:0];
  endfunction

  assign o_load    = !o_valid || (o_phase && out_pix.ready);
  assign s1_load   = !s1_valid || o_load;
  assign pop_ready = s1_load;

  always_comb begin
    sum_x  = sum_t'(p_xc) - sum_t'(p_ys);
    sum_y  = sum_t'(p_xs) + sum_t'(p_yc);
    x_next = out_t'({1'b0, cfg.origin_x}) + trunc_zero(sum_x);
    y_next = out_t'({1'b0, cfg.origin_y}) + trunc_zero(sum_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
      o_phase  <= 1'b0;
    end else begin
      if (s1_load) s1_valid <= pop_valid;
      if (o_load) begin
        o_valid <= s1_valid;
        o_phase <= 1'b0;
      end else if (out_pix.ready) begin
        o_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && pop_valid) begin
      p_xc     <= prod_t'(pop_data.dx) * prod_t'(pop_data.cos_v);
      p_ys     <= prod_t'(pop_data.dy) * prod_t'(pop_data.sin_v);
      p_xs     <= prod_t'(pop_data.dx) * prod_t'(pop_data.sin_v);
      p_yc     <= prod_t'(pop_data.dy) * prod_t'(pop_data.cos_v);
      s1_color <= pop_data.color;
      s1_eoi   <= pop_data.eoi;
    end
    if (o_load && s1_valid) begin
      o_x     <= x_next;
      o_y     <= y_next;
      o_color <= s1_color;
      o_eoi   <= s1_eoi;
    end
  end

  assign out_pix.valid      = o_valid;
  assign out_pix.draw_x     = o_phase ? o_x + out_t'(1) : o_x;
  assign out_pix.draw_y     = o_y;
  assign out_pix.draw_color = o_color;
  assign out_pix.pair_last  = o_phase;
  assign out_pix.image_done = o_phase && o_eoi;

  `ASSERT_NEXT(pair_follows_first, clk, rst, out_pix.valid && out_pix.ready && !out_pix.pair_last, out_pix.valid && out_pix.pair_last && $stable(out_pix.draw_y))
  `ASSERT_NEXT(second_is_x_plus_one, clk, rst, out_pix.valid && out_pix.ready && !out_pix.pair_last, out_pix.draw_x == out_t'($past(out_pix.draw_x) + out_t'(1)))
  `ASSERT_IMPL(done_only_on_second, clk, rst, out_pix.valid && out_pix.image_done, out_pix.pair_last)

endmodule

`default_nettype wire

/* design/bitmap_pixel_rotator.sv */
// top level: register file, front end, queue and rotate pipeline
`default_nettype none

// Rotates bitmap pixels about the anchor by a whole-degree angle, places them
// at the widget origin and emits two frame writes per pixel, at (x, y) and
// then at (x + 1, y). The output register holds each pixel for its two
// writes, one per cycle when the output is ready, while the front end and a
// two-entry queue keep taking pixels. An accepted pixel passes through the
// queue, the product stage and the output register before its first write.
// Anchor and angle are read as a pixel is accepted, origin as it enters the
// output register; write them only while no pixel is in flight.
module bitmap_pixel_rotator (
  input  logic       clk,
  input  logic       rst,
  bpr_in_if.sink     in_pix,
  bpr_out_if.source  out_pix,
  bpr_cfg_if.sink    cfg
);
  import bpr_pkg::*;

  cfg_t          cfg_regs;
  logic          push_valid;
  logic          push_ready;
  queue_entry_t  push_data;
  logic          pop_valid;
  logic          pop_ready;
  queue_entry_t  pop_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        REG_ORIGIN_X:  cfg_regs.origin_x  <= cfg.wr_data[COORD_BITS-1:0];
        REG_ORIGIN_Y:  cfg_regs.origin_y  <= cfg.wr_data[COORD_BITS-1:0];
        REG_ANCHOR_X:  cfg_regs.anchor_x  <= cfg.wr_data[COORD_BITS-1:0];
        REG_ANCHOR_Y:  cfg_regs.anchor_y  <= cfg.wr_data[COORD_BITS-1:0];
        REG_ANGLE_DEG: cfg_regs.angle_deg <= cfg.wr_data[ANGLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  bpr_front u_front (
    .in_pix     (in_pix),
    .cfg        (cfg_regs),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  bpr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bpr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_pix   (out_pix)
  );

endmodule

`default_nettype wire

/* tb/bitmap_pixel_rotator_test.sv */
// testbench for the bitmap pixel rotator: directed table, random images, self-checking
`default_nettype none

module bitmap_pixel_rotator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bpr_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEM_TARGET   = 1900;
  localparam int IDLE_PCT      = 27;
  localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam int REG_SLOTS     = 1 << CFG_IDX_BITS;
  localparam longint WATCHDOG_NS = 2_000_000;

  typedef logic [CFG_DATA_BITS-1:0] cfg_word_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    color_t col;
    logic   eoi;
  } pixel_t;

  typedef struct packed {
    out_t   x;
    out_t   y;
    color_t color;
    logic   last;
    logic   done;
  } draw_t;

  typedef struct packed {
    cfg_word_t ox;
    cfg_word_t oy;
    cfg_word_t ax;
    cfg_word_t ay;
    cfg_word_t ang;
    pixel_t    pix;
    bit        typed;
    out_t      ex;
    out_t      ey;
  } probe_t;

  logic clk = 1'b0;
  logic rst;
  bit   steady;
  int   errors;
  int   pixels_sent;

  cfg_word_t   reg_data [REG_SLOTS] = '{default: '0};
  draw_t       pending_writes [$];
  probe_t      probes [$];
  int unsigned corner_angles [9] = '{0, 1, 89, 90, 180, 270, 359, 360, 511};

  bpr_in_if  pix_in ();
  bpr_out_if pix_out ();
  bpr_cfg_if reg_wr ();

  bitmap_pixel_rotator dut (
    .clk     (clk),
    .rst     (rst),
    .in_pix  (pix_in),
    .out_pix (pix_out),
    .cfg     (reg_wr)
  );

  always #CLK_HALF clk = ~clk;

  // sin of deg (0..90) in the fixed point format of the block, q30 taylor series
  function automatic longint sine_of_degrees(input int unsigned deg);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint          acc;
    longint          val;
    ang    = (PI_Q30 * deg) / HALF_TURN;
    ang_sq = (ang * ang) >> 30;
    term   = ang;
    acc    = longint'(ang);
    for (int unsigned k = 1; k <= 10; k++) begin
      term = (term * ang_sq) >> 30;
      term = term / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    val = (acc + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
    if (val > (longint'(1) << TRIG_FRAC_BITS)) val = longint'(1) << TRIG_FRAC_BITS;
    return val;
  endfunction

  function automatic longint toward_zero(input longint v);
    return (v < 0) ? -((-v) >>> TRIG_FRAC_BITS) : (v >>> TRIG_FRAC_BITS);
  endfunction

  function automatic void queue_pair(input out_t x, input out_t y, input color_t c,
                                     input logic eoi);
    out_t nx;
    nx = x + out_t'(1);
    pending_writes.push_back('{x, y, c, 1'b0, 1'b0});
    pending_writes.push_back('{nx, y, c, 1'b1, eoi});
  endfunction

  function automatic void rotate_pixel(input pixel_t p);
    longint      dx, dy, rx, ry, sr, cr, sn, cs, x, y;
    int unsigned turn, quad, rem;
    dx   = longint'(p.sx) - longint'(reg_data[REG_ANCHOR_X][COORD_BITS-1:0]);
    dy   = longint'(p.sy) - longint'(reg_data[REG_ANCHOR_Y][COORD_BITS-1:0]);
    turn = reg_data[REG_ANGLE_DEG][ANGLE_BITS-1:0] % FULL_TURN;
    rx   = dx;
    ry   = dy;
    if (turn != 0) begin
      quad = turn / QUARTER_TURN;
      rem  = turn % QUARTER_TURN;
      sr   = sine_of_degrees(rem);
      cr   = sine_of_degrees(QUARTER_TURN - rem);
      case (quad)
        0: begin sn = sr;  cs = cr;  end
        1: begin sn = cr;  cs = -sr; end
        2: begin sn = -sr; cs = -cr; end
        default: begin sn = -cr; cs = sr; end
      endcase
      rx = toward_zero(dx * cs - dy * sn);
      ry = toward_zero(dx * sn + dy * cs);
    end
    x = longint'(reg_data[REG_ORIGIN_X][COORD_BITS-1:0]) + rx;
    y = longint'(reg_data[REG_ORIGIN_Y][COORD_BITS-1:0]) + ry;
    queue_pair(x[OUT_BITS-1:0], y[OUT_BITS-1:0], p.col, p.eoi);
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input cfg_word_t data);
    bit took;
    reg_wr.valid     <= 1'b1;
    reg_wr.reg_index <= idx;
    reg_wr.wr_data   <= data;
    do begin
      @(negedge clk);
      took = reg_wr.ready;
      @(posedge clk);
    end while (!took);
    reg_data[idx] = data;
  endtask

  // drain every pending write, then give the pipeline time to settle
  task automatic settle();
    pix_in.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input cfg_word_t ox, input cfg_word_t oy, input cfg_word_t ax,
                          input cfg_word_t ay, input cfg_word_t ang);
    cfg_word_t want [REG_ANGLE_DEG+1];
    bit        dirty;
    want  = '{ox, oy, ax, ay, ang};
    dirty = 1'b0;
    for (int i = REG_ORIGIN_X; i <= REG_ANGLE_DEG; i++)
      if (want[i] != reg_data[i]) dirty = 1'b1;
    if (dirty) begin
      settle();
      for (int i = REG_ORIGIN_X; i <= REG_ANGLE_DEG; i++)
        if (want[i] != reg_data[i]) write_reg(cfg_idx_t'(i), want[i]);
      reg_wr.valid <= 1'b0;
    end
  endtask

  task automatic send_pixel(input pixel_t p, input bit typed, input out_t ex, input out_t ey);
    bit took;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid        <= 1'b1;
    pix_in.src_x        <= p.sx;
    pix_in.src_y        <= p.sy;
    pix_in.pixel_color  <= p.col;
    pix_in.end_of_image <= p.eoi;
    do begin
      @(negedge clk);
      took = pix_in.ready;
      @(posedge clk);
    end while (!took);
    if (typed) queue_pair(ex, ey, p.col, p.eoi);
    else       rotate_pixel(p);
    pixels_sent++;
  endtask

  function automatic cfg_word_t pick_coord();
    if ($urandom_range(99) < 20) return $urandom_range(1) ? cfg_word_t'(COORD_MAX) : '0;
    return cfg_word_t'($urandom_range(COORD_MAX));
  endfunction

  function automatic cfg_word_t pick_angle();
    if ($urandom_range(99) < 25) return cfg_word_t'(corner_angles[$urandom_range(8)]);
    return cfg_word_t'($urandom);
  endfunction

  // raster-scanned bitmap with end of image on its last pixel
  task automatic send_image();
    int     w, h, bx, by;
    pixel_t p;
    w  = $urandom_range(1, 12);
    h  = $urandom_range(1, 8);
    bx = $urandom_range(0, COORD_MAX + 1 - w);
    by = $urandom_range(0, COORD_MAX + 1 - h);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        p.sx  = coord_t'(bx + c);
        p.sy  = coord_t'(by + r);
        p.col = color_t'($urandom);
        p.eoi = (r == h - 1) && (c == w - 1);
        send_pixel(p, 1'b0, '0, '0);
      end
  endtask

  task automatic send_noise();
    pixel_t p;
    repeat ($urandom_range(5, 40)) begin
      p.sx  = coord_t'($urandom);
      p.sy  = coord_t'($urandom);
      p.col = color_t'($urandom);
      p.eoi = ($urandom_range(7) == 0);
      send_pixel(p, 1'b0, '0, '0);
    end
  endtask

  always @(posedge clk) pix_out.ready <= !rst && (steady || $urandom_range(99) >= IDLE_PCT);

  always @(negedge clk) begin : draw_check
    draw_t want;
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (pending_writes.size() == 0) begin
        $error("pixel write with nothing pending: x %0d y %0d", pix_out.draw_x,
               pix_out.draw_y);
        errors++;
      end else begin
        want = pending_writes.pop_front();
        if (pix_out.draw_x !== want.x) begin
          $error("draw_x expected %0d, got %0d", want.x, pix_out.draw_x);
          errors++;
        end
        if (pix_out.draw_y !== want.y) begin
          $error("draw_y expected %0d, got %0d", want.y, pix_out.draw_y);
          errors++;
        end
        if (pix_out.draw_color !== want.color) begin
          $error("draw_color expected %06h, got %06h", want.color, pix_out.draw_color);
          errors++;
        end
        if (pix_out.pair_last !== want.last) begin
          $error("pair_last expected %0b, got %0b", want.last, pix_out.pair_last);
          errors++;
        end
        if (pix_out.image_done !== want.done) begin
          $error("image_done expected %0b, got %0b", want.done, pix_out.image_done);
          errors++;
        end
      end
    end
  end

  initial begin
    #(WATCHDOG_NS);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int phase;
    rst                 = 1'b1;
    steady              = 1'b0;
    errors              = 0;
    pixels_sent         = 0;
    pix_in.valid        = 1'b0;
    pix_in.src_x        = '0;
    pix_in.src_y        = '0;
    pix_in.pixel_color  = '0;
    pix_in.end_of_image = 1'b0;
    pix_out.ready       = 1'b0;
    reg_wr.valid        = 1'b0;
    reg_wr.reg_index    = '0;
    reg_wr.wr_data      = '0;

    //            ox      oy      ax      ay      ang     sx      sy      color      eoi
    probes.push_back('{10'h000, 10'h000, 10'h000, 10'h000, 10'd0,
                       '{10'h000, 10'h000, 24'h000000, 1'b0}, 1'b1, 12'sd0, 12'sd0});
    probes.push_back('{10'h000, 10'h000, 10'h000, 10'h000, 10'd0,
                       '{10'h3FF, 10'h3FF, 24'hFFFFFF, 1'b1}, 1'b1, 12'sd1023, 12'sd1023});
    probes.push_back('{10'h3FF, 10'h3FF, 10'h000, 10'h000, 10'd0,
                       '{10'h3FF, 10'h3FF, 24'h123456, 1'b0}, 1'b1, 12'sd2046, 12'sd2046});
    probes.push_back('{10'h000, 10'h000, 10'h3FF, 10'h3FF, 10'd0,
                       '{10'h000, 10'h000, 24'hAAAAAA, 1'b1}, 1'b1, -12'sd1023, -12'sd1023});
    probes.push_back('{10'h000, 10'h000, 10'h3FF, 10'h3FF, 10'd0,
                       '{10'h3FF, 10'h000, 24'h555555, 1'b0}, 1'b1, 12'sd0, -12'sd1023});
    foreach (corner_angles[i])
      probes.push_back('{10'h200, 10'h200, 10'h200, 10'h200, cfg_word_t'(corner_angles[i]),
                         '{10'h300, 10'h280, color_t'(24'h0F0F0F << i), i[0]},
                         1'b0, 12'sd0, 12'sd0});
    probes.push_back('{10'h200, 10'h200, 10'h200, 10'h200, 10'd45,
                       '{10'h300, 10'h280, 24'h00FF00, 1'b0}, 1'b0, 12'sd0, 12'sd0});
    probes.push_back('{10'h200, 10'h200, 10'h200, 10'h200, 10'd91,
                       '{10'h300, 10'h280, 24'hFF00FF, 1'b1}, 1'b0, 12'sd0, 12'sd0});
    // upper angle bit is dropped, leaving 511, which is 151 degrees
    probes.push_back('{10'h200, 10'h200, 10'h200, 10'h200, 10'h3FF,
                       '{10'h300, 10'h280, 24'h0000FF, 1'b0}, 1'b0, 12'sd0, 12'sd0});
    // rotated x lands right at the top of the range, so x + 1 wraps negative
    probes.push_back('{10'h3FF, 10'h3FF, 10'h000, 10'h1AA, 10'd45,
                       '{10'h3FF, 10'h000, 24'hC0FFEE, 1'b0}, 1'b0, 12'sd0, 12'sd0});
    probes.push_back('{10'h3FF, 10'h3FF, 10'h000, 10'h3FF, 10'd45,
                       '{10'h3FF, 10'h000, 24'h7E7E7E, 1'b1}, 1'b0, 12'sd0, 12'sd0});
    probes.push_back('{10'h000, 10'h000, 10'h3FF, 10'h000, 10'd45,
                       '{10'h000, 10'h3FF, 24'h818181, 1'b0}, 1'b0, 12'sd0, 12'sd0});
    probes.push_back('{10'h000, 10'h000, 10'h3FF, 10'h3FF, 10'd180,
                       '{10'h000, 10'h000, 24'hFFFFFF, 1'b1}, 1'b0, 12'sd0, 12'sd0});

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // writes to indexes past the register file must leave it untouched
    for (int i = REG_ANGLE_DEG + 1; i < REG_SLOTS; i++) begin
      write_reg(cfg_idx_t'(i), '1);
      reg_data[i] = '0;
    end
    reg_wr.valid <= 1'b0;

    foreach (probes[i]) begin
      set_regs(probes[i].ox, probes[i].oy, probes[i].ax, probes[i].ay, probes[i].ang);
      send_pixel(probes[i].pix, probes[i].typed, probes[i].ex, probes[i].ey);
    end

    phase = 0;
    while (pixels_sent < ITEM_TARGET) begin
      steady <= (phase >= 6 && phase < 10);
      set_regs($urandom_range(1) ? pick_coord() : reg_data[REG_ORIGIN_X],
               $urandom_range(1) ? pick_coord() : reg_data[REG_ORIGIN_Y],
               $urandom_range(1) ? pick_coord() : reg_data[REG_ANCHOR_X],
               $urandom_range(1) ? pick_coord() : reg_data[REG_ANCHOR_Y],
               $urandom_range(1) ? pick_angle() : reg_data[REG_ANGLE_DEG]);
      if ($urandom_range(99) < 80) repeat ($urandom_range(1, 3)) send_image();
      else send_noise();
      phase++;
    end

    pix_in.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
